[rtl/pcf_pkg.sv]
package pcf_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    localparam int HEAD_LEN = 41;
    localparam int TAIL_LEN = 16;
    localparam int CNT_W    = 6;

    localparam logic [CNT_W-1:0] HEAD_LAST    = CNT_W'(HEAD_LEN - 1);
    localparam logic [CNT_W-1:0] IHDR_CRC_LO  = 6'd12;
    localparam logic [CNT_W-1:0] IHDR_CRC_HI  = 6'd28;
    localparam logic [CNT_W-1:0] IHDR_CRC_END = 6'd32;
    localparam logic [CNT_W-1:0] IDAT_TYPE_LO = 6'd37;
    localparam logic [3:0]       TAIL_CRC_END = 4'd3;
    localparam logic [3:0]       TAIL_LAST    = 4'(TAIL_LEN - 1);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;

    typedef enum logic [2:0] {
        PH_HEAD = 3'b001,
        PH_DATA = 3'b010,
        PH_TAIL = 3'b100
    } phase_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] head_byte(
        input logic [CNT_W-1:0] idx,
        input logic [15:0]      w,
        input logic [15:0]      h,
        input logic [23:0]      len,
        input logic [31:0]      crc
    );
        logic [31:0] fin;
        logic [7:0]  r;
        fin = ~crc;
        unique case (idx)
            6'd0:    r = 8'd137;
            6'd1:    r = 8'd80;
            6'd2:    r = 8'd78;
            6'd3:    r = 8'd71;
            6'd4:    r = 8'd13;
            6'd5:    r = 8'd10;
            6'd6:    r = 8'd26;
            6'd7:    r = 8'd10;
            6'd11:   r = 8'd13;
            6'd12:   r = 8'h49;
            6'd13:   r = 8'h48;
            6'd14:   r = 8'h44;
            6'd15:   r = 8'h52;
            6'd18:   r = w[15:8];
            6'd19:   r = w[7:0];
            6'd22:   r = h[15:8];
            6'd23:   r = h[7:0];
            6'd24:   r = 8'd8;
            6'd25:   r = 8'd2;
            6'd29:   r = fin[31:24];
            6'd30:   r = fin[23:16];
            6'd31:   r = fin[15:8];
            6'd32:   r = fin[7:0];
            6'd34:   r = len[23:16];
            6'd35:   r = len[15:8];
            6'd36:   r = len[7:0];
            6'd37:   r = 8'h49;
            6'd38:   r = 8'h44;
            6'd39:   r = 8'h41;
            6'd40:   r = 8'h54;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] tail_byte(input logic [3:0] idx, input logic [31:0] crc);
        logic [31:0] fin;
        logic [7:0]  r;
        fin = ~crc;
        unique case (idx)
            4'd0:    r = fin[31:24];
            4'd1:    r = fin[23:16];
            4'd2:    r = fin[15:8];
            4'd3:    r = fin[7:0];
            4'd8:    r = 8'h49;
            4'd9:    r = 8'h45;
            4'd10:   r = 8'h4E;
            4'd11:   r = 8'h44;
            4'd12:   r = 8'd174;
            4'd13:   r = 8'd66;
            4'd14:   r = 8'd96;
            4'd15:   r = 8'd130;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/png_container_framer_crc32_unit.sv]
// A word accepted on an idle port opens a file and waits in the input register while
// 41 header words go out, with input held off, then the data word. Inside a file, one
// data word per cycle while s_tvalid and m_tready stay high; each file ends with 16
// trailer words. Output register set by m_tready.
// Reset (rst_n low, asynchronous): no file open, CRC all ones, output empty,
// image_width, image_height and data_length all 1.
module png_container_framer_crc32_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast
);

    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [23:0] length_reg;

    pcf_pkg::phase_t               phase_reg, phase_next;
    logic [pcf_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [31:0]                   crc_reg, crc_next;
    logic [23:0]                   rem_reg, rem_next;
    logic                          in_full_reg, in_full_next;
    logic [7:0]                    in_byte_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    out_byte_reg;
    logic                          out_last_reg;

    logic        load_ok;
    logic        emit;
    logic        take;
    logic [7:0]  sel_byte;
    logic        sel_last;
    logic [23:0] open_len;
    logic [23:0] rem_dec;

    assign load_ok  = !out_valid_reg || m_tready;
    assign s_tready = !in_full_reg || take;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign open_len = (length_reg == 24'd0) ? 24'd1 : length_reg;
    assign rem_dec  = rem_reg - 24'd1;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        rem_next   = rem_reg;
        emit       = 1'b0;
        take       = 1'b0;
        sel_byte   = 8'd0;
        sel_last   = 1'b0;
        unique case (phase_reg)
            pcf_pkg::PH_HEAD:
            begin
                sel_byte = pcf_pkg::head_byte(cnt_reg, width_reg, height_reg, rem_reg, crc_reg);
                emit     = in_full_reg && load_ok;
                if (emit)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == '0)
                    begin
                        rem_next = open_len;
                    end
                    if ((cnt_reg >= pcf_pkg::IHDR_CRC_LO && cnt_reg <= pcf_pkg::IHDR_CRC_HI)
                        || cnt_reg >= pcf_pkg::IDAT_TYPE_LO)
                    begin
                        crc_next = pcf_pkg::crc_byte(crc_reg, sel_byte);
                    end
                    else if (cnt_reg == pcf_pkg::IHDR_CRC_END)
                    begin
                        crc_next = pcf_pkg::CRC_ONES;
                    end
                    if (cnt_reg == pcf_pkg::HEAD_LAST)
                    begin
                        cnt_next   = '0;
                        phase_next = pcf_pkg::PH_DATA;
                    end
                end
            end
            pcf_pkg::PH_DATA:
            begin
                sel_byte = in_byte_reg;
                emit     = in_full_reg && load_ok;
                take     = emit;
                if (emit)
                begin
                    crc_next = pcf_pkg::crc_byte(crc_reg, in_byte_reg);
                    rem_next = rem_dec;
                    if (rem_dec == 24'd0)
                    begin
                        phase_next = pcf_pkg::PH_TAIL;
                    end
                end
            end
            pcf_pkg::PH_TAIL:
            begin
                sel_byte = pcf_pkg::tail_byte(cnt_reg[3:0], crc_reg);
                sel_last = (cnt_reg[3:0] == pcf_pkg::TAIL_LAST);
                emit     = load_ok;
                if (emit)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg[3:0] == pcf_pkg::TAIL_CRC_END)
                    begin
                        crc_next = pcf_pkg::CRC_ONES;
                    end
                    if (sel_last)
                    begin
                        cnt_next   = '0;
                        phase_next = pcf_pkg::PH_HEAD;
                    end
                end
            end
            default:
            begin
                phase_next = pcf_pkg::PH_HEAD;
            end
        endcase
    end

    always_comb
    begin
        in_full_next = in_full_reg;
        if (s_tvalid && s_tready)
        begin
            in_full_next = 1'b1;
        end
        else if (take)
        begin
            in_full_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 16'd1;
            height_reg    <= 16'd1;
            length_reg    <= 24'd1;
            phase_reg     <= pcf_pkg::PH_HEAD;
            cnt_reg       <= '0;
            crc_reg       <= pcf_pkg::CRC_ONES;
            rem_reg       <= 24'd0;
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pcf_pkg::REG_WIDTH:  width_reg  <= cfg_data[15:0];
                    pcf_pkg::REG_HEIGHT: height_reg <= cfg_data[15:0];
                    pcf_pkg::REG_LENGTH: length_reg <= cfg_data;
                    default:             ;
                endcase
            end
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            crc_reg       <= crc_next;
            rem_reg       <= rem_next;
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (emit)
        begin
            out_byte_reg <= sel_byte;
            out_last_reg <= sel_last;
        end
    end

    a_data_has_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pcf_pkg::PH_DATA) |-> (rem_reg != 24'd0))
        else $error("data phase with no bytes remaining");

    a_last_closes_file: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (phase_reg == pcf_pkg::PH_HEAD))
        else $error("last word shown while file still open");

    a_crc_fresh_at_open: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pcf_pkg::PH_HEAD && cnt_reg == '0) |-> (crc_reg == pcf_pkg::CRC_ONES))
        else $error("crc not reset at file open");

    a_hold_input_outside_data: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != pcf_pkg::PH_DATA && in_full_reg) |-> !s_tready)
        else $error("input taken during header or trailer");

endmodule

[tb/png_container_framer_crc32_unit_tb.sv]
module png_container_framer_crc32_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_NONE = 2'd3;

    localparam int RAND_ITEMS    = 410;
    localparam int QUIET_ITEMS   = 60;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRESSURE_FILE = 3;
    localparam int PRESSURE_LEN  = 48;

    localparam int NO_PIN       = -1;
    localparam int AT_SIG       = 0;
    localparam int AT_WIDTH_HI  = 18;
    localparam int AT_WIDTH_LO  = 19;
    localparam int AT_HEIGHT_LO = 23;
    localparam int AT_LENGTH_LO = 36;
    localparam int AT_DATA      = 41;
    localparam int AT_TAIL_END  = 16;
    localparam int AT_FILE_END  = 57;

    localparam logic [7:0] PNG_SIG [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                           8'd13, 8'd10, 8'd26, 8'd10};
    localparam logic [7:0] IEND_CHUNK [12] = '{8'h00, 8'h00, 8'h00, 8'h00,
                                               8'h49, 8'h45, 8'h4E, 8'h44,
                                               8'd174, 8'd66, 8'd96, 8'd130};

    typedef struct packed {
        logic [7:0] val;
        logic       last;
    } word_t;

    typedef enum logic {
        ROW_CFG,
        ROW_BYTE
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [23:0] val;
        int          pin_at;
        logic [7:0]  pin_val;
    } stim_row_t;

    localparam int DIR_ROWS = 22;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_BYTE, pcf_pkg::REG_WIDTH,  24'h000000, AT_SIG,       8'd137},
        '{ROW_BYTE, pcf_pkg::REG_WIDTH,  24'h0000FF, AT_DATA,      8'hFF},
        '{ROW_CFG,  pcf_pkg::REG_WIDTH,  24'h00FFFF, NO_PIN,       8'h00},
        '{ROW_CFG,  pcf_pkg::REG_HEIGHT, 24'h000000, NO_PIN,       8'h00},
        '{ROW_CFG,  pcf_pkg::REG_LENGTH, 24'h000000, NO_PIN,       8'h00},
        '{ROW_BYTE, pcf_pkg::REG_WIDTH,  24'h0000A5, AT_WIDTH_HI,  8'hFF},
        '{ROW_BYTE, pcf_pkg::REG_WIDTH,  24'h00005A, AT_LENGTH_LO, 8'h01},
        '{ROW_CFG,  pcf_pkg::REG_WIDTH,  24'h000000, NO_PIN,       8'h00},
        '{ROW_CFG,  pcf_pkg::REG_HEIGHT, 24'h00FFFF, NO_PIN,       8'h00},
        '{ROW_CFG,  pcf_pkg::REG_LENGTH, 24'h000003, NO_PIN,       8'h00},
        '{ROW_BYTE, pcf_pkg::REG_WIDTH,  24'h000001, AT_HEIGHT_LO, 8'hFF},
        '{ROW_CFG,  pcf_pkg::REG_LENGTH, 24'hFFFFFF, NO_PIN,       8'h00},
        '{ROW_CFG,  REG_NONE,            24'h000002, NO_PIN,       8'h00},
        '{ROW_CFG,  pcf_pkg::REG_WIDTH,  24'h001234, NO_PIN,       8'h00},
        '{ROW_BYTE, pcf_pkg::REG_WIDTH,  24'h000080, NO_PIN,       8'h00},
        '{ROW_BYTE, pcf_pkg::REG_WIDTH,  24'h00007F, AT_TAIL_END,  8'd130},
        '{ROW_CFG,  pcf_pkg::REG_LENGTH, 24'h000002, NO_PIN,       8'h00},
        '{ROW_BYTE, pcf_pkg::REG_WIDTH,  24'h000055, AT_WIDTH_LO,  8'h34},
        '{ROW_BYTE, pcf_pkg::REG_WIDTH,  24'h0000AA, NO_PIN,       8'h00},
        '{ROW_CFG,  pcf_pkg::REG_HEIGHT, 24'h000001, NO_PIN,       8'h00},
        '{ROW_CFG,  pcf_pkg::REG_LENGTH, 24'h000001, NO_PIN,       8'h00},
        '{ROW_BYTE, pcf_pkg::REG_WIDTH,  24'h00003C, AT_FILE_END,  8'd130}
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [23:0] cfg_data  = 24'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    png_container_framer_crc32_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // framer state as seen from outside
    logic [15:0] img_width   = 16'd1;
    logic [15:0] img_height  = 16'd1;
    logic [23:0] idat_len    = 24'd1;
    logic [31:0] idat_crc    = 32'hFFFF_FFFF;
    logic [23:0] bytes_left  = 24'd0;
    logic        file_open   = 1'b0;

    word_t file_words [$];
    word_t step_words [$];

    int  mismatch_cnt = 0;
    bit  tx_jitter    = 1'b1;
    bit  rx_jitter    = 1'b1;
    bit  hold_req     = 1'b0;

    function automatic logic [31:0] crc_fold(logic [31:0] c, logic [7:0] d);
        logic fb;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb)
                c = c ^ pcf_pkg::CRC_POLY;
        end
        return c;
    endfunction

    function automatic void emit(logic [7:0] v, logic last);
        word_t w;
        w.val  = v;
        w.last = last;
        step_words.push_back(w);
    endfunction

    function automatic void emit32(logic [31:0] v);
        for (int i = 3; i >= 0; i--)
            emit(v[8*i +: 8], 1'b0);
    endfunction

    function automatic void open_png();
        logic [7:0]  ihdr [17];
        logic [31:0] c;
        logic [23:0] len;
        len  = (idat_len == 24'd0) ? 24'd1 : idat_len;
        ihdr = '{8'h49, 8'h48, 8'h44, 8'h52, 8'h00, 8'h00,
                 img_width[15:8], img_width[7:0], 8'h00, 8'h00,
                 img_height[15:8], img_height[7:0],
                 8'd8, 8'd2, 8'd0, 8'd0, 8'd0};
        foreach (PNG_SIG[i])
            emit(PNG_SIG[i], 1'b0);
        emit32(32'd13);
        c = pcf_pkg::CRC_ONES;
        foreach (ihdr[i])
        begin
            emit(ihdr[i], 1'b0);
            c = crc_fold(c, ihdr[i]);
        end
        emit32(~c);
        emit32({8'h00, len});
        c = pcf_pkg::CRC_ONES;
        emit(8'h49, 1'b0);
        emit(8'h44, 1'b0);
        emit(8'h41, 1'b0);
        emit(8'h54, 1'b0);
        c = crc_fold(c, 8'h49);
        c = crc_fold(c, 8'h44);
        c = crc_fold(c, 8'h41);
        c = crc_fold(c, 8'h54);
        idat_crc   = c;
        bytes_left = len;
        file_open  = 1'b1;
    endfunction

    function automatic void frame_byte(logic [7:0] d);
        step_words.delete();
        if (!file_open || bytes_left == 24'd0)
            open_png();
        emit(d, 1'b0);
        idat_crc   = crc_fold(idat_crc, d);
        bytes_left = bytes_left - 24'd1;
        if (bytes_left == 24'd0)
        begin
            emit32(~idat_crc);
            foreach (IEND_CHUNK[i])
                emit(IEND_CHUNK[i], i == 11);
            idat_crc  = pcf_pkg::CRC_ONES;
            file_open = 1'b0;
        end
    endfunction

    function automatic logic [15:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom());
    endfunction

    function automatic logic [23:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 24'd0;
        if (r <= 6)
            return 24'($urandom_range(1, 8));
        if (r <= 8)
            return 24'($urandom_range(9, 40));
        return 24'($urandom_range(41, 120));
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        unique case (idx)
            pcf_pkg::REG_WIDTH:  img_width  = val[15:0];
            pcf_pkg::REG_HEIGHT: img_height = val[15:0];
            pcf_pkg::REG_LENGTH: idat_len   = val;
            default: ;
        endcase
    endtask

    task automatic send_byte(logic [7:0] d, int pin_at, logic [7:0] pin_val);
        cfg_we <= 1'b0;
        if (tx_jitter && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        frame_byte(d);
        if (pin_at != NO_PIN && pin_at < step_words.size())
            step_words[pin_at].val = pin_val;
        foreach (step_words[i])
            file_words.push_back(step_words[i]);
    endtask

    // hold input and wait for the output to catch up
    task automatic drain();
        s_tvalid <= 1'b0;
        cfg_we   <= 1'b0;
        while (file_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        word_t want;
        if (m_tvalid && m_tready)
        begin
            if (file_words.size() == 0)
            begin
                mismatch_cnt++;
                $display("%0t unexpected word: expected none, actual %02h last %0b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                want = file_words.pop_front();
                if (m_tdata !== want.val)
                begin
                    mismatch_cnt++;
                    $display("%0t out_byte mismatch: expected %02h, actual %02h",
                             $time, want.val, m_tdata);
                end
                if (m_tlast !== want.last)
                begin
                    mismatch_cnt++;
                    $display("%0t out_last mismatch: expected %0b, actual %0b",
                             $time, want.last, m_tlast);
                end
            end
        end
    end

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (rx_jitter && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("png_container_framer_crc32_unit regression: fail");
        $finish;
    end

    initial
    begin
        int  sent;
        int  file_idx;
        int  file_bytes;
        int  mid;
        bit  prev_cfg;
        bit  quiet;

        sent     = 0;
        file_idx = 0;
        prev_cfg = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                if (!prev_cfg)
                    drain();
                cfg_write(dir_rows[i].idx, dir_rows[i].val);
                prev_cfg = 1'b1;
            end
            else
            begin
                send_byte(dir_rows[i].val[7:0], dir_rows[i].pin_at, dir_rows[i].pin_val);
                prev_cfg = 1'b0;
            end
        end

        while (sent < RAND_ITEMS)
        begin
            quiet = (sent >= RAND_ITEMS - QUIET_ITEMS);
            drain();
            if ($urandom_range(0, 1))
                cfg_write(pcf_pkg::REG_WIDTH, {8'h00, pick_dim()});
            if ($urandom_range(0, 1))
                cfg_write(pcf_pkg::REG_HEIGHT, {8'h00, pick_dim()});
            if ($urandom_range(0, 7) == 0)
                cfg_write(REG_NONE, 24'($urandom()));
            if (file_idx == PRESSURE_FILE)
                cfg_write(pcf_pkg::REG_LENGTH, 24'(PRESSURE_LEN));
            else if ($urandom_range(0, 3) != 0)
                cfg_write(pcf_pkg::REG_LENGTH, pick_length());

            file_bytes = (idat_len == 24'd0) ? 1 : int'(idat_len);
            tx_jitter  = !quiet && ($urandom_range(0, 2) != 0);
            rx_jitter  = !quiet && ($urandom_range(0, 2) != 0);
            if (file_idx == PRESSURE_FILE)
                hold_req = 1'b1;
            mid = (file_bytes > 2 && $urandom_range(0, 5) == 0) ?
                  int'($urandom_range(1, file_bytes - 1)) : 0;

            for (int i = 0; i < file_bytes; i++)
            begin
                // registers change mid-file; only the next file picks them up
                if (mid != 0 && i == mid)
                begin
                    drain();
                    cfg_write(pcf_pkg::REG_WIDTH, {8'h00, pick_dim()});
                    cfg_write(pcf_pkg::REG_HEIGHT, {8'h00, pick_dim()});
                    cfg_write(pcf_pkg::REG_LENGTH, pick_length());
                end
                send_byte(8'($urandom()), NO_PIN, 8'h00);
                sent++;
            end
            file_idx++;
        end

        s_tvalid <= 1'b0;
        while (file_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_cnt == 0 && file_words.size() == 0)
            $display("png_container_framer_crc32_unit regression: pass");
        else
            $display("png_container_framer_crc32_unit regression: fail");
        $finish;
    end

endmodule
